FILE: rtl/core/fpa_pkg.sv
// shared types and constants of the fixed-point arithmetic unit
`default_nettype none
package fpa_pkg;
	localparam int DATA_W      = 32;
	localparam int PROD_W      = 2 * DATA_W;
	localparam int WID_W       = 6;
	localparam int DIV_STAGES  = PROD_W;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 6;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = 1;
	localparam int QCNT_W      = 2;

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		RND_ZERO = 2'd0,
		RND_EVEN = 2'd1,
		RND_POS  = 2'd2,
		RND_NEG  = 2'd3
	} rnd_t;

	localparam logic [CFG_IDX_W-1:0] REG_INT_BITS   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAC_BITS  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ROUND_MODE = 2'd2;

	localparam logic [5:0] INT_BITS_RST  = 6'd16;
	localparam logic [4:0] FRAC_BITS_RST = 5'd16;

	typedef struct packed {
		logic [5:0] int_bits;
		logic [4:0] frac_bits;
		rnd_t       round_mode;
	} cfg_t;

	// classified item between front and back
	typedef struct packed {
		op_t              op;
		rnd_t             mode;
		logic             neg;
		logic             dz;
		logic [WID_W-1:0] w;
		logic [5:0]       sh;
		logic [DATA_W-1:0] x;
		logic [DATA_W-1:0] y;
	} item_t;

	// one divider stage
	typedef struct packed {
		op_t               op;
		rnd_t              mode;
		logic              neg;
		logic              dz;
		logic [WID_W-1:0]  w;
		logic [5:0]        sh;
		logic [PROD_W-1:0] num;
		logic [DATA_W-1:0] dvs;
		logic [DATA_W-1:0] rem;
		logic [PROD_W-1:0] val;
	} pipe_t;
endpackage
`default_nettype wire

FILE: rtl/core/fixed_point_alu_rounding.sv
// top level: config registers, front end, queue and back end
// throughput: one word per cycle while the output does not stall; the 64-stage divider pipeline sets the latency
// a two-entry queue and the front register take up to three more words while output waits
// reset: arst_n clears all valid state; int_bits 16, frac_bits 16, round_mode toward zero
`default_nettype none
module fixed_point_alu_rounding (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        s_tvalid,
	output logic                       s_tready,
	input  wire  [63:0]                s_tdata,   // operand_a[31:0], operand_b[63:32]
	input  wire  [1:0]                 s_tuser,   // req_type[1:0]
	output logic                       m_tvalid,
	input  wire                        m_tready,
	output logic [31:0]                m_tdata,   // result_value[31:0]
	output logic [1:0]                 m_tuser,   // result_negative[0], divide_by_zero[1]
	input  wire                        cfg_we,
	input  wire  [fpa_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire  [fpa_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import fpa_pkg::*;

	cfg_t  cfg_q;
	logic  f_valid, f_ready, q_valid, q_ready;
	item_t f_item, q_item;
	logic  res_neg, res_dz;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.int_bits   <= INT_BITS_RST;
			cfg_q.frac_bits  <= FRAC_BITS_RST;
			cfg_q.round_mode <= RND_ZERO;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_INT_BITS:   cfg_q.int_bits   <= cfg_wdata;
				REG_FRAC_BITS:  cfg_q.frac_bits  <= cfg_wdata[4:0];
				REG_ROUND_MODE: cfg_q.round_mode <= rnd_t'(cfg_wdata[1:0]);
				default: begin
				end
			endcase
		end
	end

	fpa_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.op        (op_t'(s_tuser)),
		.a         (s_tdata[31:0]),
		.b         (s_tdata[63:32]),
		.cfg       (cfg_q),
		.out_valid (f_valid),
		.out_ready (f_ready),
		.out_item  (f_item)
	);

	fpa_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_item  (f_item),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready),
		.pop_item   (q_item)
	);

	fpa_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (q_valid),
		.in_ready        (q_ready),
		.in_item         (q_item),
		.out_valid       (m_tvalid),
		.out_ready       (m_tready),
		.result_value    (m_tdata),
		.result_negative (res_neg),
		.divide_by_zero  (res_dz)
	);

	assign m_tuser = {res_dz, res_neg};
endmodule
`default_nettype wire

FILE: rtl/core/fpa_front.sv
// front end: format clamp, operand masking, magnitudes and signs
`default_nettype none
module fpa_front (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      in_valid,
	output logic                     in_ready,
	input  wire  fpa_pkg::op_t       op,
	input  wire  [31:0]              a,
	input  wire  [31:0]              b,
	input  wire  fpa_pkg::cfg_t      cfg,
	output logic                     out_valid,
	input  wire                      out_ready,
	output fpa_pkg::item_t           out_item
);
	import fpa_pkg::*;

	logic [5:0]        a_eff;
	logic [4:0]        b_eff;
	logic [6:0]        sum7;
	logic [WID_W-1:0]  w;
	logic [4:0]        wm1;
	logic [DATA_W-1:0] mask, xm, ym, xa, ya;
	logic              nx, ny;
	logic [6:0]        dsh7;
	item_t             item;
	logic              valid_q;
	item_t             item_q;

	always_comb begin
		a_eff = cfg.int_bits;
		if (cfg.int_bits == 6'd0) begin
			a_eff = 6'd1;
		end else if (cfg.int_bits > 6'd32) begin
			a_eff = 6'd32;
		end
		sum7 = {1'b0, a_eff} + {2'b0, cfg.frac_bits};
		b_eff = cfg.frac_bits;
		if (sum7 > 7'd32) begin
			b_eff = 5'(6'd32 - a_eff);
		end
		w    = a_eff + {1'b0, b_eff};
		wm1  = w[4:0] - 5'd1;
		mask = 32'hFFFF_FFFF >> (6'd32 - w);
		xm   = a & mask;
		ym   = b & mask;
		nx   = xm[wm1];
		ny   = ym[wm1];
		xa   = nx ? ((32'd0 - xm) & mask) : xm;
		ya   = ny ? ((32'd0 - ym) & mask) : ym;
		dsh7 = 7'd64 - {1'b0, a_eff} - {1'b0, b_eff, 1'b0};

		item.op   = op;
		item.mode = cfg.round_mode;
		item.w    = w;
		item.x    = xm;
		item.y    = ym;
		item.neg  = 1'b0;
		item.dz   = 1'b0;
		item.sh   = 6'd0;
		case (op)
			OP_MUL: begin
				item.x   = xa;
				item.y   = ya;
				item.neg = nx ^ ny;
				item.sh  = {1'b0, b_eff};
			end
			OP_DIV: begin
				item.x   = xa;
				item.y   = ya;
				item.dz  = (ym == 32'd0);
				item.neg = (nx ^ ny) && (ym != 32'd0);
				item.sh  = dsh7[5:0];
			end
			default: begin
			end
		endcase
	end

	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_item  = item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_q <= item;
		end
	end
endmodule
`default_nettype wire

FILE: rtl/core/fpa_queue.sv
// two-entry queue between front and back
`default_nettype none
module fpa_queue (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 push_valid,
	output logic                push_ready,
	input  wire  fpa_pkg::item_t push_item,
	output logic                pop_valid,
	input  wire                 pop_ready,
	output fpa_pkg::item_t      pop_item
);
	import fpa_pkg::*;

	item_t             mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              push, pop;

	assign push_ready = (count_q != QCNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_item   = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end
endmodule
`default_nettype wire

FILE: rtl/core/fpa_back.sv
// back end: add/sub/multiply, bit-per-stage divider, rounding and sign fix-up
`default_nettype none
module fpa_back (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_ready,
	input  wire  fpa_pkg::item_t in_item,
	output logic                 out_valid,
	input  wire                  out_ready,
	output logic [31:0]          result_value,
	output logic                 result_negative,
	output logic                 divide_by_zero
);
	import fpa_pkg::*;

	logic              ce;
	pipe_t             prep;
	logic [DATA_W-1:0] pmask;
	logic [6:0]        nsh7;

	logic              valid_q [DIV_STAGES+1];
	pipe_t             div_q   [DIV_STAGES+1];

	// rounding stage
	pipe_t             fin;
	logic [PROD_W-1:0] shifted, lost_mask, below_mask;
	logic              lost_any, half_bit, below_any, inc;
	logic              valid_s2, inc_s2, neg_s2, dz_s2;
	logic [DATA_W-1:0] q_s2;
	logic [WID_W-1:0]  w_s2;
	op_t               op_s2;

	// output stage
	logic [DATA_W-1:0] mag, res, omask;
	logic [4:0]        wm1;
	logic              valid_s3, neg_s3, dz_s3;
	logic [DATA_W-1:0] res_s3;
	op_t               op_s3;

	assign ce       = !valid_s3 || out_ready;
	assign in_ready = ce;

	always_comb begin
		pmask     = 32'hFFFF_FFFF >> (6'd32 - in_item.w);
		nsh7      = 7'd64 - {1'b0, in_item.w};
		prep.op   = in_item.op;
		prep.mode = in_item.mode;
		prep.neg  = in_item.neg;
		prep.dz   = in_item.dz;
		prep.w    = in_item.w;
		prep.sh   = in_item.sh;
		prep.num  = {32'd0, in_item.x} << nsh7[5:0];
		prep.dvs  = in_item.y;
		prep.rem  = '0;
		case (in_item.op)
			OP_ADD:  prep.val = {32'd0, (in_item.x + in_item.y) & pmask};
			OP_SUB:  prep.val = {32'd0, (in_item.x - in_item.y) & pmask};
			OP_MUL:  prep.val = in_item.x * in_item.y;
			default: prep.val = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q[0] <= 1'b0;
		end else if (ce) begin
			valid_q[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			div_q[0] <= prep;
		end
	end

	// one quotient bit per stage, msb first
	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
		logic [DATA_W:0] rem2;
		logic            take;
		pipe_t           nxt;

		always_comb begin
			rem2     = {div_q[k].rem, div_q[k].num[PROD_W-1]};
			take     = (div_q[k].op == OP_DIV) && (rem2 >= {1'b0, div_q[k].dvs});
			nxt      = div_q[k];
			nxt.num  = {div_q[k].num[PROD_W-2:0], 1'b0};
			nxt.rem  = take ? 32'(rem2 - {1'b0, div_q[k].dvs}) : rem2[DATA_W-1:0];
			if (div_q[k].op == OP_DIV) begin
				nxt.val = {div_q[k].val[PROD_W-2:0], take};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_q[k+1] <= 1'b0;
			end else if (ce) begin
				valid_q[k+1] <= valid_q[k];
			end
		end

		always_ff @(posedge clk) begin
			if (ce) begin
				div_q[k+1] <= nxt;
			end
		end
	end

	always_comb begin
		fin        = div_q[DIV_STAGES];
		shifted    = fin.val >> fin.sh;
		lost_mask  = (64'd1 << fin.sh) - 64'd1;
		lost_any   = |(fin.val & lost_mask);
		half_bit   = (fin.sh != 6'd0) && fin.val[fin.sh - 6'd1];
		below_mask = (fin.sh <= 6'd1) ? 64'd0 : ((64'd1 << (fin.sh - 6'd1)) - 64'd1);
		below_any  = |(fin.val & below_mask);
		case (fin.mode)
			RND_EVEN: inc = half_bit && (below_any || shifted[0]);
			RND_POS:  inc = !fin.neg && lost_any;
			RND_NEG:  inc = fin.neg && lost_any;
			default:  inc = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (ce) begin
			valid_s2 <= valid_q[DIV_STAGES];
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			q_s2   <= shifted[DATA_W-1:0];
			inc_s2 <= inc;
			neg_s2 <= fin.neg;
			dz_s2  <= fin.dz;
			w_s2   <= fin.w;
			op_s2  <= fin.op;
		end
	end

	// only the low word survives the final wrap
	always_comb begin
		omask = 32'hFFFF_FFFF >> (6'd32 - w_s2);
		wm1   = w_s2[4:0] - 5'd1;
		mag   = q_s2 + {31'd0, inc_s2};
		res   = (neg_s2 ? (32'd0 - mag) : mag) & omask;
		if (dz_s2) begin
			res = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			res_s3 <= res;
			neg_s3 <= res[wm1];
			dz_s3  <= dz_s2;
			op_s3  <= op_s2;
		end
	end

	assign out_valid       = valid_s3;
	assign result_value    = res_s3;
	assign result_negative = neg_s3;
	assign divide_by_zero  = dz_s3;

	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && dz_s3 |-> res_s3 == 32'd0 && !neg_s3)
		else $error("divide by zero result not cleared");
	a_dz_div: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && dz_s3 |-> op_s3 == OP_DIV)
		else $error("divide by zero flag on non-divide");
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !ce |=> valid_s2 && $stable(q_s2))
		else $error("rounding stage lost a word during stall");
	a_neg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && res_s3 == 32'd0 |-> !neg_s3)
		else $error("negative flag on zero result");
endmodule
`default_nettype wire

FILE: verif/fixed_point_alu_rounding_tb.sv
// testbench of the fixed-point arithmetic unit: directed, random and stall tests against a predictor
`timescale 1ns / 1ps
module fixed_point_alu_rounding_tb;
	import fpa_pkg::*;

	typedef struct {
		logic [31:0] val;
		logic        neg;
		logic        dz;
	} alu_result_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [63:0] s_tdata;   // operand_a[31:0], operand_b[63:32]
	logic [1:0]  s_tuser;   // req_type[1:0]
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;   // result_value[31:0]
	logic [1:0]  m_tuser;   // result_negative[0], divide_by_zero[1]
	logic        cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	alu_result_t pending_results[$];
	int          errors;
	int          words_sent;
	int          words_checked;
	int          settings_used;
	int          cycle_count;
	int          hold_cycles;
	bit          no_gaps;

	// local copy of the format and rounding registers
	logic [5:0] fmt_int;
	logic [4:0] fmt_frac;
	logic [1:0] fmt_mode;

	fixed_point_alu_rounding uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 2000000) begin
			$display("%0t timeout", $time);
			$display("fixed_point_alu_rounding_tb: errors");
			$finish;
		end
	end

	function automatic logic [63:0] round_mag(input logic [63:0] mag, input logic neg,
			input int sh);
		logic [63:0] lost, q, half;
		if (sh == 0)
			return mag;
		lost = mag & ((64'd1 << sh) - 64'd1);
		q    = mag >> sh;
		half = 64'd1 << (sh - 1);
		case (rnd_t'(fmt_mode))
			RND_EVEN: begin
				if ((lost & half) != 0 && ((lost & (half - 64'd1)) != 0 || q[0]))
					q = q + 64'd1;
			end
			RND_POS: begin
				if (!neg && lost != 0)
					q = q + 64'd1;
			end
			RND_NEG: begin
				if (neg && lost != 0)
					q = q + 64'd1;
			end
			default: ;
		endcase
		return q;
	endfunction

	function automatic int eff_int();
		int ia;
		ia = fmt_int;
		if (ia < 1)
			ia = 1;
		if (ia > 32)
			ia = 32;
		return ia;
	endfunction

	function automatic int eff_width();
		int ia, ib;
		ia = eff_int();
		ib = fmt_frac;
		if (ia + ib > 32)
			ib = 32 - ia;
		return ia + ib;
	endfunction

	function automatic alu_result_t compute_alu(input op_t op, input logic [31:0] ra,
			input logic [31:0] rb);
		alu_result_t r;
		int ia, ib, w;
		logic [63:0] mask, x, y, res;
		logic nx, ny, neg;
		ia   = eff_int();
		w    = eff_width();
		ib   = w - ia;
		mask = (64'd1 << w) - 64'd1;
		x    = {32'd0, ra} & mask;
		y    = {32'd0, rb} & mask;
		r.dz = 1'b0;
		if (op == OP_ADD)
			res = (x + y) & mask;
		else if (op == OP_SUB)
			res = (x - y) & mask;
		else begin
			nx  = x[w-1];
			ny  = y[w-1];
			neg = nx ^ ny;
			if (nx)
				x = (64'd0 - x) & mask;
			if (ny)
				y = (64'd0 - y) & mask;
			if (op == OP_MUL)
				res = round_mag(x * y, neg, ib);
			else if (y == 0) begin
				r.dz = 1'b1;
				res  = 0;
				neg  = 1'b0;
			end else
				res = round_mag((x << (64 - w)) / y, neg, 64 - ia - 2 * ib);
			if (neg)
				res = 64'd0 - res;
			res = res & mask;
		end
		r.val = res[31:0];
		r.neg = res[w-1];
		return r;
	endfunction

	task automatic send_word(input op_t op, input logic [31:0] a, input logic [31:0] b);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {b, a};
		s_tuser  <= op;
		do
			@(posedge clk);
		while (!s_tready);
		pending_results.push_back(compute_alu(op, a, b));
		words_sent++;
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [5:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_INT_BITS:   fmt_int  = data;
			REG_FRAC_BITS:  fmt_frac = data[4:0];
			REG_ROUND_MODE: fmt_mode = data[1:0];
			default: ;
		endcase
	endtask

	task automatic set_format(input logic [5:0] ib, input logic [5:0] fb, input rnd_t mode);
		drain();
		write_reg(REG_INT_BITS, ib);
		write_reg(REG_FRAC_BITS, fb);
		write_reg(REG_ROUND_MODE, {4'd0, mode});
		settings_used++;
	endtask

	function automatic logic [31:0] pick_operand();
		int w;
		w = eff_width();
		case ($urandom_range(0, 6))
			0, 1, 2: return $urandom;
			3: return $urandom_range(0, 15);
			4: return 32'hFFFF_FFFF - $urandom_range(0, 15);
			// most negative value of the format, with noise above the width
			5: return (32'd1 << (w - 1)) | ($urandom & ~((32'd2 << (w - 1)) - 32'd1));
			default: return 32'd0;
		endcase
	endfunction

	task automatic test_directed();
		send_word(OP_ADD, 32'h7FFF_FFFF, 32'h0000_0001);
		send_word(OP_ADD, 32'h8000_0000, 32'h8000_0000);
		send_word(OP_SUB, 32'h0000_0000, 32'h0000_0001);
		send_word(OP_SUB, 32'h8000_0000, 32'h7FFF_FFFF);
		send_word(OP_MUL, 32'h8000_0000, 32'h8000_0000);
		send_word(OP_MUL, 32'hFFFF_FFFF, 32'h0000_0001);
		send_word(OP_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_word(OP_DIV, 32'h0001_0000, 32'h0000_0000);
		send_word(OP_DIV, 32'h8000_0000, 32'h0000_0000);
		send_word(OP_DIV, 32'h0001_0000, 32'h0003_0000);
		send_word(OP_DIV, 32'hFFFF_0000, 32'h0003_0000);
		send_word(OP_DIV, 32'h8000_0000, 32'hFFFF_FFFF);
		send_word(OP_DIV, 32'h0000_0001, 32'h7FFF_FFFF);
		// integer format: multiply discards nothing; upper operand bits ignored
		set_format(6'd8, 6'd0, RND_EVEN);
		send_word(OP_MUL, 32'hABCD_EF85, 32'h1234_5603);
		send_word(OP_ADD, 32'hFFFF_FF7F, 32'h0000_0101);
		send_word(OP_DIV, 32'h0000_0080, 32'h0000_0003);
		// zero int_bits acts as one; a tiny negative product rounds to minus one, and to zero when rounding toward zero
		set_format(6'd0, 6'd4, RND_NEG);
		send_word(OP_MUL, 32'h0000_001F, 32'h0000_0001);
		send_word(OP_MUL, 32'h0000_0010, 32'h0000_0010);
		set_format(6'd0, 6'd4, RND_ZERO);
		send_word(OP_MUL, 32'h0000_001F, 32'h0000_0001);
		send_word(OP_DIV, 32'h0000_0001, 32'h0000_0000);
		// int_bits above the limit, frac bits clamped away
		set_format(6'd63, 6'd31, RND_POS);
		send_word(OP_MUL, 32'h0000_0003, 32'h0000_0005);
		send_word(OP_DIV, 32'h0000_0007, 32'h0000_0002);
	endtask

	task automatic test_random_formats();
		logic [5:0] int_list[12]  = '{1, 1, 32, 32, 0, 63, 8, 4, 16, 12, 2, 20};
		logic [5:0] frac_list[12] = '{0, 31, 0, 31, 5, 20, 8, 3, 16, 20, 29, 11};
		for (int f = 0; f < 12; f++) begin
			for (int m = 0; m < 4; m++) begin
				set_format(int_list[f], frac_list[f], rnd_t'(m));
				no_gaps = (m == 2);
				for (int i = 0; i < 32; i++)
					send_word(op_t'($urandom_range(0, 3)), pick_operand(), pick_operand());
			end
		end
		no_gaps = 1'b0;
	endtask

	// more words than the pipeline, queue and front register hold together
	task automatic test_backpressure();
		set_format(6'd16, 6'd16, RND_EVEN);
		no_gaps     = 1'b1;
		hold_cycles = 300;
		for (int i = 0; i < 100; i++)
			send_word(op_t'($urandom_range(0, 3)), pick_operand(), pick_operand());
		no_gaps = 1'b0;
	endtask

	// result side: random stalls, plus one long hold on request
	initial begin
		int stall;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_cycles > 0) begin
				m_tready <= 1'b0;
				repeat (hold_cycles) @(posedge clk);
				hold_cycles = 0;
			end
			stall = no_gaps ? 0 : $urandom_range(0, 12);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do
				@(posedge clk);
			while (!m_tvalid && hold_cycles == 0);
		end
	end

	always @(posedge clk) begin
		alu_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				$display("%0t unexpected word: got %h/%b", $time, m_tdata, m_tuser);
				errors++;
			end else begin
				want = pending_results.pop_front();
				words_checked++;
				if (m_tdata !== want.val || m_tuser[0] !== want.neg
						|| m_tuser[1] !== want.dz) begin
					$display("%0t mismatch: expected %h neg %b dz %b, got %h neg %b dz %b",
						$time, want.val, want.neg, want.dz, m_tdata, m_tuser[0], m_tuser[1]);
					errors++;
				end
			end
		end
	end

	initial begin
		arst_n        = 1'b0;
		s_tvalid      = 1'b0;
		s_tdata       = '0;
		s_tuser       = '0;
		cfg_we        = 1'b0;
		cfg_index     = '0;
		cfg_wdata     = '0;
		errors        = 0;
		words_sent    = 0;
		words_checked = 0;
		settings_used = 0;
		cycle_count   = 0;
		hold_cycles   = 0;
		no_gaps       = 1'b0;
		fmt_int       = INT_BITS_RST;
		fmt_frac      = FRAC_BITS_RST;
		fmt_mode      = RND_ZERO;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_formats();
		test_backpressure();
		drain();
		if (pending_results.size() != 0)
			errors++;
		$display("sent %0d words, checked %0d results over %0d format/rounding settings",
			words_sent, words_checked, settings_used);
		$display("all four operations, divide by zero and a long output hold were exercised");
		if (errors == 0)
			$display("fixed_point_alu_rounding_tb: clean");
		else
			$display("fixed_point_alu_rounding_tb: errors");
		$finish;
	end
endmodule
